### hdl/rpyu_pkg.sv
// Package for the RGB to packed YUV converter with vertical pixel doubling.
// Holds field widths, BT.601 coefficients in thousandths and the scaling helpers.
// No dependencies; used by rgb_to_packed_yuv_upscale.
`default_nettype none

package rpyu_pkg;

    // Field widths of the streams and the configuration port.
    localparam int ADDR_W     = 22;
    localparam int DATA_W     = 32;
    localparam int PIXEL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int LP_REG_W   = 11;
    localparam int IW_REG_W   = 12;

    // Default sizes handed to the top level.
    localparam int DEF_MAX_LINE_PIXELS = 1024;
    localparam int DEF_MAX_LINES       = 1024;
    localparam int DEF_MAX_IMAGE_WIDTH = 2048;

    // Reset values of the configuration registers.
    localparam logic [LP_REG_W-1:0] LINE_PIXELS_RST = LP_REG_W'(1024);
    localparam logic [IW_REG_W-1:0] IMAGE_WIDTH_RST = IW_REG_W'(2048);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKING_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PIXELS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd3;

    // Input format and packing order codes.
    localparam logic FMT_RGB565   = 1'b0;
    localparam logic FMT_ARGB8888 = 1'b1;
    localparam logic PACK_YUY2    = 1'b0;
    localparam logic PACK_UYVY    = 1'b1;

    // BT.601 coefficients, scaled by 1000.
    localparam int Y_R = 257;
    localparam int Y_G = 504;
    localparam int Y_B = 98;
    localparam int Y_OFS = 16000;
    localparam int U_R = -148;
    localparam int U_G = -291;
    localparam int U_B = 439;
    localparam int V_R = 439;
    localparam int V_G = -368;
    localparam int V_B = -71;
    localparam int UV_OFS = 128000;

    // Width of a scaled channel sum, with a sign bit.
    localparam int SUM_W = 20;

    // Sums at or above this value clamp to 255.
    localparam int SCALE_LIMIT = 256000;

    // ceil(2^28 / 1000): exact floor division by 1000 for sums below SCALE_LIMIT.
    localparam int RECIP_SHIFT = 28;
    localparam logic [18:0] RECIP_1000 = 19'd268436;

    // Floor a scaled sum to a channel value in 0..255.
    function automatic logic [7:0] clamp_scaled(input logic signed [SUM_W-1:0] s);
        logic [36:0] prod;
        logic [7:0]  q;
        prod = 37'(s[17:0]) * 37'(RECIP_1000);
        if (s < 0) begin
            q = 8'h00;
        end else if (s >= SUM_W'(SCALE_LIMIT)) begin
            q = 8'hff;
        end else begin
            q = prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
        return q;
    endfunction

    // Pack one pixel into a 4-byte word, lowest address byte first.
    function automatic logic [DATA_W-1:0] pack_word(input logic [7:0] y,
                                                    input logic [7:0] u,
                                                    input logic [7:0] v,
                                                    input logic       order);
        logic [DATA_W-1:0] w;
        if (order == PACK_UYVY) begin
            w = {y, v, y, u};
        end else begin
            w = {v, y, u, y};
        end
        return w;
    endfunction

endpackage

`default_nettype wire

### hdl/rgb_to_packed_yuv_upscale.sv
// RGB565 / ARGB8888 to packed YUY2 or UYVY converter with 2x vertical copy.
// Three register stages: input capture, channel sums and address, output words.
// Depends on rpyu_pkg.
//
// Each accepted pixel item produces two result items: the packed word for the upper row
// (tlast low) and the same word for the lower row, half an image width further on
// (tlast high), both on the single result port; the first word leaves from the output
// register after the input capture and sum stages. tuser marks the first pixel of a
// frame and clears the column and row counters before that pixel. The row counter stops
// at the last row, so extra lines overwrite it. The user must write the configuration
// only while the block is empty; the block itself does not enforce this.
`default_nettype none

module rgb_to_packed_yuv_upscale #(
    parameter int MAX_LINE_PIXELS = rpyu_pkg::DEF_MAX_LINE_PIXELS,
    parameter int MAX_LINES       = rpyu_pkg::DEF_MAX_LINES,
    parameter int MAX_IMAGE_WIDTH = rpyu_pkg::DEF_MAX_IMAGE_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [rpyu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rpyu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Pixel items.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [rpyu_pkg::PIXEL_W-1:0]        s_axis_tdata,  // [31:0] pixel
    input  wire logic                                s_axis_tuser,  // [0] frame_start
    // Packed word items.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [55:0]                              m_axis_tdata,  // [21:0] word_address,
                                                                    // [53:22] word_data,
                                                                    // [55:54] zero
    output logic                                     m_axis_tlast   // last (lower-row copy)
);

    localparam int COL_W = $clog2(MAX_LINE_PIXELS);
    localparam int ROW_W = $clog2(MAX_LINES);
    localparam int LEN_W = (COL_W + 1 > rpyu_pkg::LP_REG_W) ? COL_W + 1 : rpyu_pkg::LP_REG_W;
    localparam int WID_W = ($clog2(MAX_IMAGE_WIDTH + 1) > rpyu_pkg::IW_REG_W)
                           ? $clog2(MAX_IMAGE_WIDTH + 1) : rpyu_pkg::IW_REG_W;
    localparam int AW    = rpyu_pkg::ADDR_W;
    localparam int DW    = rpyu_pkg::DATA_W;
    localparam int SW    = rpyu_pkg::SUM_W;

    // Configuration registers.
    logic                              r_input_format;
    logic                              r_packing_order;
    logic [rpyu_pkg::LP_REG_W-1:0]     r_line_pixels;
    logic [rpyu_pkg::IW_REG_W-1:0]     r_image_width;

    // Position counters.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // Stage 1: captured pixel and position.
    logic             r_s1_valid;
    logic [15:0]      r_s1_p565;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;

    // Stage 2: channel sums and addresses.
    logic                 r_s2_valid;
    logic signed [SW-1:0] r_s2_ysum;
    logic signed [SW-1:0] r_s2_usum;
    logic signed [SW-1:0] r_s2_vsum;
    logic [AW-1:0]        r_s2_base;
    logic [AW-1:0]        r_s2_half;

    // Output stage: one packed word, sent twice.
    logic          r_o_valid;
    logic          r_beat;
    logic [DW-1:0] r_o_data;
    logic [AW-1:0] r_o_addr;
    logic [AW-1:0] r_o_addr_hi;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_s2_free;
    logic                 w_s1_free;
    logic [COL_W-1:0]     w_col_base;
    logic [ROW_W-1:0]     w_row_base;
    logic [COL_W:0]       w_col_inc;
    logic [LEN_W-1:0]     w_linelen;
    logic [COL_W-1:0]     n_col;
    logic [ROW_W-1:0]     n_row;
    logic [15:0]          w_p565;
    logic [WID_W-1:0]     w_width;
    logic [7:0]           w_r8;
    logic [7:0]           w_g8;
    logic [7:0]           w_b8;
    logic signed [SW-1:0] n_ysum;
    logic signed [SW-1:0] n_usum;
    logic signed [SW-1:0] n_vsum;

    // Handshake: each stage loads when it is empty or is emptied in this cycle.
    assign w_out_free    = !r_o_valid || (m_axis_tready && r_beat);
    assign w_s2_free     = !r_s2_valid || w_out_free;
    assign w_s1_free     = !r_s1_valid || w_s2_free;
    assign s_axis_tready = w_s1_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_format  <= rpyu_pkg::FMT_RGB565;
            r_packing_order <= rpyu_pkg::PACK_YUY2;
            r_line_pixels   <= rpyu_pkg::LINE_PIXELS_RST;
            r_image_width   <= rpyu_pkg::IMAGE_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpyu_pkg::CFG_INPUT_FORMAT:  r_input_format  <= i_cfg_data[0];
                rpyu_pkg::CFG_PACKING_ORDER: r_packing_order <= i_cfg_data[0];
                rpyu_pkg::CFG_LINE_PIXELS:
                    r_line_pixels <= i_cfg_data[rpyu_pkg::LP_REG_W-1:0];
                rpyu_pkg::CFG_IMAGE_WIDTH:
                    r_image_width <= i_cfg_data[rpyu_pkg::IW_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective line length: zero acts as one, and it never exceeds the maximum.
    always_comb begin
        if (r_line_pixels == '0) begin
            w_linelen = LEN_W'(1);
        end else if (LEN_W'(r_line_pixels) > LEN_W'(MAX_LINE_PIXELS)) begin
            w_linelen = LEN_W'(MAX_LINE_PIXELS);
        end else begin
            w_linelen = LEN_W'(r_line_pixels);
        end
    end

    // Position of the incoming pixel and the next counter values.
    always_comb begin
        w_col_base = s_axis_tuser ? '0 : r_col;
        w_row_base = s_axis_tuser ? '0 : r_row;
        w_col_inc  = {1'b0, w_col_base} + 1'b1;
        n_col      = w_col_base + 1'b1;
        n_row      = w_row_base;
        if (LEN_W'(w_col_inc) >= w_linelen) begin
            n_col = '0;
            if (w_row_base < ROW_W'(MAX_LINES - 1)) begin
                n_row = w_row_base + 1'b1;
            end
        end
    end

    // Reduce ARGB8888 to RGB565 by keeping the top bits of each channel.
    always_comb begin
        if (r_input_format == rpyu_pkg::FMT_ARGB8888) begin
            w_p565 = {s_axis_tdata[23:19], s_axis_tdata[15:10], s_axis_tdata[7:3]};
        end else begin
            w_p565 = s_axis_tdata[15:0];
        end
    end

    // Counters advance on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_beat     <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_free) begin
                r_o_valid <= r_s2_valid;
                r_beat    <= 1'b0;
            end else if (m_axis_tready) begin
                r_beat <= 1'b1;
            end
        end
    end

    // Stage 1 capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_p565 <= w_p565;
            r_s1_col  <= w_col_base;
            r_s1_row  <= w_row_base;
        end
    end

    // Widen channels to 8 bits by bit replication and form the scaled sums.
    always_comb begin
        w_r8   = {r_s1_p565[15:11], r_s1_p565[15:13]};
        w_g8   = {r_s1_p565[10:5], r_s1_p565[10:9]};
        w_b8   = {r_s1_p565[4:0], r_s1_p565[4:2]};
        n_ysum = SW'(rpyu_pkg::Y_R * int'(w_r8) + rpyu_pkg::Y_G * int'(w_g8)
                     + rpyu_pkg::Y_B * int'(w_b8) + rpyu_pkg::Y_OFS);
        n_usum = SW'(rpyu_pkg::U_R * int'(w_r8) + rpyu_pkg::U_G * int'(w_g8)
                     + rpyu_pkg::U_B * int'(w_b8) + rpyu_pkg::UV_OFS);
        n_vsum = SW'(rpyu_pkg::V_R * int'(w_r8) + rpyu_pkg::V_G * int'(w_g8)
                     + rpyu_pkg::V_B * int'(w_b8) + rpyu_pkg::UV_OFS);
    end

    // Row stride, limited to the largest supported width.
    always_comb begin
        if (WID_W'(r_image_width) > WID_W'(MAX_IMAGE_WIDTH)) begin
            w_width = WID_W'(MAX_IMAGE_WIDTH);
        end else begin
            w_width = WID_W'(r_image_width);
        end
    end

    // Stage 2: sums and upper-row address.
    always_ff @(posedge i_clk) begin
        if (w_s2_free && r_s1_valid) begin
            r_s2_ysum <= n_ysum;
            r_s2_usum <= n_usum;
            r_s2_vsum <= n_vsum;
            r_s2_base <= AW'(32'(r_s1_row) * 32'(w_width)) + AW'(r_s1_col);
            r_s2_half <= AW'(w_width >> 1);
        end
    end

    // Output stage: the lower-row address replaces the upper one after the first word.
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_s2_valid) begin
                r_o_data    <= rpyu_pkg::pack_word(rpyu_pkg::clamp_scaled(r_s2_ysum),
                                                   rpyu_pkg::clamp_scaled(r_s2_usum),
                                                   rpyu_pkg::clamp_scaled(r_s2_vsum),
                                                   r_packing_order);
                r_o_addr    <= r_s2_base;
                r_o_addr_hi <= r_s2_base + r_s2_half;
            end
        end else if (m_axis_tready) begin
            r_o_addr <= r_o_addr_hi;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tlast  = r_beat;
    assign m_axis_tdata  = {2'b00, r_o_data, r_o_addr};

    // The upper-row word is always followed by its lower-row copy.
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
        else $error("lower-row copy did not follow the upper-row word");

    // Both copies carry the same packed word.
    a_pair_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tdata[53:22] == $past(m_axis_tdata[53:22]))
        else $error("packed word changed between the two copies");

    // Input stalls only when results are waiting downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // Counters stay inside the image.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) <= MAX_LINES - 1) && (32'(r_col) < MAX_LINE_PIXELS))
        else $error("position counter out of range");

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for rgb_to_packed_yuv_upscale: drives pixel items, predicts each pair of
// packed YUV words with a local model of the converter and checks every result item.
// Depends on rpyu_pkg and rgb_to_packed_yuv_upscale.
`timescale 1ns / 1ps

module testbench;

    // Limits of the block as instantiated with its default parameters.
    localparam int LINE_CAP  = rpyu_pkg::DEF_MAX_LINE_PIXELS;
    localparam int ROW_CAP   = rpyu_pkg::DEF_MAX_LINES;
    localparam int WIDTH_CAP = rpyu_pkg::DEF_MAX_IMAGE_WIDTH;

    // Run length guard, in clock cycles.
    localparam int CYCLE_LIMIT = 400000;

    // One result item: destination word, packed bytes and lower-row marker.
    typedef struct packed {
        logic [rpyu_pkg::ADDR_W-1:0] address;
        logic [rpyu_pkg::DATA_W-1:0] data;
        logic                        lower;
    } t_yuv_word;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rpyu_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rpyu_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [rpyu_pkg::PIXEL_W-1:0]    s_axis_tdata;  // [31:0] pixel
    logic                            s_axis_tuser;  // [0] frame_start
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [55:0]                     m_axis_tdata;  // [21:0] word_address, [53:22] word_data
    logic                            m_axis_tlast;  // lower-row copy

    // Local copy of the configuration and of the position counters.
    logic                            cfg_format;
    logic                            cfg_order;
    logic [rpyu_pkg::LP_REG_W-1:0]   cfg_line_pixels;
    logic [rpyu_pkg::IW_REG_W-1:0]   cfg_image_width;
    int unsigned                     column_pos;
    int unsigned                     row_pos;

    t_yuv_word             expected_words[$];
    int                    mismatch_count;
    int                    cycle_count;

    // Idling controls for the sender and the receiver.
    bit                    tx_idle_on;
    bit                    rx_idle_on;
    int                    hold_request;

    rgb_to_packed_yuv_upscale uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock source.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a stuck handshake ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Floor a sum held in thousandths to a channel value in 0..255.
    function automatic logic [7:0] floor_thousandths(input int s);
        int q;
        if (s < 0) begin
            return 8'd0;
        end
        q = s / 1000;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Convert one RGB565 pixel to a packed 4-byte YUV word in the given byte order.
    function automatic logic [rpyu_pkg::DATA_W-1:0] yuv_from_565(input logic [15:0] p,
                                                                 input logic order);
        int         r;
        int         g;
        int         b;
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
        r = int'({p[15:11], p[15:13]});
        g = int'({p[10:5], p[10:9]});
        b = int'({p[4:0], p[4:2]});
        y = floor_thousandths(257 * r + 504 * g + 98 * b + 16000);
        u = floor_thousandths(-148 * r - 291 * g + 439 * b + 128000);
        v = floor_thousandths(439 * r - 368 * g - 71 * b + 128000);
        if (order == rpyu_pkg::PACK_UYVY) begin
            return {y, v, y, u};
        end
        return {v, y, u, y};
    endfunction

    // Work out the two words that an accepted pixel causes and advance the counters.
    task automatic predict_yuv_words(input logic [rpyu_pkg::PIXEL_W-1:0] pix, input logic fs);
        logic [15:0]   p565;
        logic [31:0]   word;
        int unsigned   width;
        int unsigned   line_len;
        int unsigned   base;
        t_yuv_word     upper;
        t_yuv_word     lower;
        if (fs) begin
            column_pos = 0;
            row_pos    = 0;
        end
        if (cfg_format == rpyu_pkg::FMT_ARGB8888) begin
            p565 = {pix[23:19], pix[15:10], pix[7:3]};
        end else begin
            p565 = pix[15:0];
        end
        word  = yuv_from_565(p565, cfg_order);
        width = (32'(cfg_image_width) > WIDTH_CAP) ? 32'(WIDTH_CAP) : 32'(cfg_image_width);
        base  = row_pos * width + column_pos;
        upper.address = base[rpyu_pkg::ADDR_W-1:0];
        upper.data    = word;
        upper.lower   = 1'b0;
        lower.address = rpyu_pkg::ADDR_W'(base + (width >> 1));
        lower.data    = word;
        lower.lower   = 1'b1;
        expected_words.push_back(upper);
        expected_words.push_back(lower);
        line_len = (cfg_line_pixels == '0) ? 32'd1 : 32'(cfg_line_pixels);
        if (line_len > LINE_CAP) begin
            line_len = LINE_CAP;
        end
        column_pos++;
        if (column_pos >= line_len) begin
            column_pos = 0;
            if (row_pos < ROW_CAP - 1) begin
                row_pos++;
            end
        end
    endtask

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got 0x%08h, expected 0x%08h, cycle %0d",
                 what, got, want, cycle_count);
    endtask

    // Compare every accepted result item with the oldest expected word.
    always @(posedge i_clk) begin
        t_yuv_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected item, address", 32'(m_axis_tdata[21:0]), 32'd0);
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata[21:0] !== want.address) begin
                    report_mismatch("word_address", 32'(m_axis_tdata[21:0]),
                                    32'(want.address));
                end
                if (m_axis_tdata[53:22] !== want.data) begin
                    report_mismatch("word_data", m_axis_tdata[53:22], want.data);
                end
                if (m_axis_tlast !== want.lower) begin
                    report_mismatch("last", 32'(m_axis_tlast), 32'(want.lower));
                end
            end
        end
    end

    // Result side: random stall bursts, plus a long counted hold when a test asks for one.
    initial begin
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one pixel item; called just after a falling edge, returns at one.
    // The valid may stay high on return, so that the next item follows at once.
    task automatic send_pixel(input logic [rpyu_pkg::PIXEL_W-1:0] pix, input logic fs);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_yuv_words(pix, fs);
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    // Withdraw the pixel stream before anything other than another item.
    task automatic stop_send();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait until every expected word has come back, then let the pipeline settle.
    task automatic wait_drain();
        while (expected_words.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    // Write one configuration register while the block is empty.
    task automatic write_reg(input logic [rpyu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rpyu_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            rpyu_pkg::CFG_INPUT_FORMAT:  cfg_format      = value[0];
            rpyu_pkg::CFG_PACKING_ORDER: cfg_order       = value[0];
            rpyu_pkg::CFG_LINE_PIXELS:   cfg_line_pixels = value[rpyu_pkg::LP_REG_W-1:0];
            rpyu_pkg::CFG_IMAGE_WIDTH:   cfg_image_width = value[rpyu_pkg::IW_REG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Set the line length and image width for the next phase.
    task automatic set_geometry(input int line_pixels, input int image_width);
        stop_send();
        wait_drain();
        write_reg(rpyu_pkg::CFG_LINE_PIXELS, rpyu_pkg::CFG_DATA_W'(line_pixels));
        write_reg(rpyu_pkg::CFG_IMAGE_WIDTH, rpyu_pkg::CFG_DATA_W'(image_width));
    endtask

    // Reset defaults: RGB565 in, YUY2 out; color extremes and ignored upper bits.
    task automatic test_default_settings();
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'h0000_ffff, 1'b0);
        send_pixel(32'h0000_f800, 1'b0);
        send_pixel(32'h0000_07e0, 1'b0);
        send_pixel(32'h0000_001f, 1'b0);
        send_pixel(32'hffff_0000, 1'b0);
    endtask

    // Both input formats and both byte orders, with alpha and low channel bits set.
    task automatic test_formats_and_orders();
        stop_send();
        wait_drain();
        write_reg(rpyu_pkg::CFG_INPUT_FORMAT, rpyu_pkg::CFG_DATA_W'(rpyu_pkg::FMT_ARGB8888));
        write_reg(rpyu_pkg::CFG_PACKING_ORDER, rpyu_pkg::CFG_DATA_W'(rpyu_pkg::PACK_UYVY));
        send_pixel(32'hffff_ffff, 1'b1);
        send_pixel(32'hff00_0000, 1'b0);
        send_pixel(32'h0007_0307, 1'b0);
        send_pixel(32'h00ff_0000, 1'b0);
        send_pixel(32'h0000_ff00, 1'b0);
        send_pixel(32'h0000_00ff, 1'b0);
        stop_send();
        wait_drain();
        write_reg(rpyu_pkg::CFG_PACKING_ORDER, rpyu_pkg::CFG_DATA_W'(rpyu_pkg::PACK_YUY2));
        send_pixel(32'h8040_c020, 1'b0);
        stop_send();
        wait_drain();
        write_reg(rpyu_pkg::CFG_INPUT_FORMAT, rpyu_pkg::CFG_DATA_W'(rpyu_pkg::FMT_RGB565));
    endtask

    // Line length and image width corner cases.
    task automatic test_line_geometry();
        // A zero line length acts as one pixel per line; odd widths halve downward.
        set_geometry(0, 7);
        send_pixel($urandom, 1'b1);
        send_pixel($urandom, 1'b0);
        // Zero width puts both copies on one address.
        set_geometry(3, 0);
        send_pixel($urandom, 1'b1);
        send_pixel($urandom, 1'b0);
        // Oversized line length and width act as their maximum values.
        set_geometry(2047, 4095);
        send_pixel($urandom, 1'b1);
        send_pixel($urandom, 1'b0);
        // Largest legal settings, then the smallest.
        set_geometry(1024, 2048);
        send_pixel($urandom, 1'b0);
        set_geometry(1, 2);
        send_pixel($urandom, 1'b1);
        send_pixel($urandom, 1'b0);
    endtask

    // One pixel per line, run past the last row so the row counter saturates.
    task automatic test_row_saturation();
        set_geometry(1, 4095);
        send_pixel($urandom, 1'b1);
        repeat (ROW_CAP + 6) send_pixel($urandom, 1'b0);
        send_pixel($urandom, 1'b1);
    endtask

    // The receiver holds off long enough that the block stalls its input.
    task automatic test_output_hold();
        set_geometry(5, 16);
        tx_idle_on   = 1'b0;
        hold_request = 300;
        repeat (30) send_pixel($urandom, $urandom_range(0, 9) == 0);
        tx_idle_on   = 1'b1;
    endtask

    // Random phases, each with random settings, mostly small line lengths.
    task automatic test_random_phases();
        int lp;
        int iw;
        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 7))
                0:       lp = 0;
                1:       lp = 1;
                2, 3:    lp = $urandom_range(2, 8);
                4:       lp = $urandom_range(9, 64);
                5:       lp = LINE_CAP;
                6:       lp = $urandom_range(LINE_CAP + 1, 2047);
                default: lp = $urandom_range(1, LINE_CAP);
            endcase
            case ($urandom_range(0, 7))
                0:       iw = 0;
                1:       iw = $urandom_range(0, 20) | 1;
                2, 3:    iw = $urandom_range(2, 64);
                4:       iw = WIDTH_CAP;
                5:       iw = $urandom_range(WIDTH_CAP + 1, 4095);
                6:       iw = $urandom_range(0, 4095);
                default: iw = 2;
            endcase
            // The last phase runs with no idling on either side.
            if (phase == 7) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            set_geometry(lp, iw);
            write_reg(rpyu_pkg::CFG_INPUT_FORMAT,
                      rpyu_pkg::CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(rpyu_pkg::CFG_PACKING_ORDER,
                      rpyu_pkg::CFG_DATA_W'($urandom_range(0, 1)));
            for (int n = 0; n < 110; n++) begin
                // Now and then the sender pauses until every result is back.
                if ($urandom_range(0, 59) == 0) begin
                    stop_send();
                    wait_drain();
                end
                send_pixel($urandom, $urandom_range(0, 39) == 0);
            end
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        mismatch_count = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_request  = 0;
        cfg_format      = rpyu_pkg::FMT_RGB565;
        cfg_order       = rpyu_pkg::PACK_YUY2;
        cfg_line_pixels = rpyu_pkg::LINE_PIXELS_RST;
        cfg_image_width = rpyu_pkg::IMAGE_WIDTH_RST;
        column_pos      = 0;
        row_pos         = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_default_settings();
        test_formats_and_orders();
        test_line_geometry();
        test_row_saturation();
        test_output_hold();
        test_random_phases();

        stop_send();
        wait_drain();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
